// ===== rtl/core/highest_priority_ready_queue_top_assert.svh =====
// assertion macros used by the ready queue top rtl
`ifndef HIGHEST_PRIORITY_READY_QUEUE_TOP_ASSERT_SVH
`define HIGHEST_PRIORITY_READY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define HPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define HPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hpq_pkg.sv =====
// types and codes shared by the ready queue modules
`default_nettype none

package hpq_pkg;

  localparam logic FUNC_INSERT   = 1'b0;
  localparam logic FUNC_SCHEDULE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  proc_id;
    logic [7:0]  priority_req;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        found;
    logic [7:0]  chosen_id;
    logic [15:0] run_time;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic extract;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/hpq_cell.sv =====
// one slot of the sorted ready queue chain
`default_nettype none

module hpq_cell #(
  parameter int unsigned PrioBits = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hpq_pkg::cell_cmd_t   cmd_i,
  input  wire logic [7:0]           new_id_i,
  input  wire logic [PrioBits-1:0]  new_prio_i,
  input  wire logic [15:0]          new_burst_i,
  input  wire logic                 left_ge_i,
  input  wire logic                 left_valid_i,
  input  wire logic [7:0]           left_id_i,
  input  wire logic [PrioBits-1:0]  left_prio_i,
  input  wire logic [15:0]          left_burst_i,
  input  wire logic                 right_valid_i,
  input  wire logic [7:0]           right_id_i,
  input  wire logic [PrioBits-1:0]  right_prio_i,
  input  wire logic [15:0]          right_burst_i,
  output logic                      ge_o,
  output logic                      valid_o,
  output logic [7:0]                id_o,
  output logic [PrioBits-1:0]       prio_o,
  output logic [15:0]               burst_o
);

  logic                valid_q, valid_d;
  logic [7:0]          id_q, id_d;
  logic [PrioBits-1:0] prio_q, prio_d;
  logic [15:0]         burst_q, burst_d;

  // this entry stays ahead of the new one (equal priority: older first)
  assign ge_o = valid_q && (prio_q >= new_prio_i);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    prio_d  = prio_q;
    burst_d = burst_q;
    if (cmd_i.insert) begin
      if (!ge_o) begin
        if (left_ge_i) begin
          valid_d = 1'b1;
          id_d    = new_id_i;
          prio_d  = new_prio_i;
          burst_d = new_burst_i;
        end else begin
          valid_d = left_valid_i;
          id_d    = left_id_i;
          prio_d  = left_prio_i;
          burst_d = left_burst_i;
        end
      end
    end else if (cmd_i.extract) begin
      valid_d = right_valid_i;
      id_d    = right_id_i;
      prio_d  = right_prio_i;
      burst_d = right_burst_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    prio_q  <= prio_d;
    burst_q <= burst_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign prio_o  = prio_q;
  assign burst_o = burst_q;

endmodule

`default_nettype wire

// ===== rtl/core/highest_priority_ready_queue_top.sv =====
// highest-priority-first ready queue built as a sorted chain of cells
`default_nettype none

// Ready queue of up to QUEUE_DEPTH process entries, kept as a chain of cells
// sorted by priority (larger first) and, among equal priorities, by arrival
// (older first). Cell 0 always holds the entry a schedule would pick. An item
// is transferred at a rising edge with start high and busy low. An insert
// broadcasts the new entry to all cells: cells that stay ahead keep their
// entry, the first cell behind them takes the new one and the rest shift one
// place toward the tail. A schedule hands cell 0 out and shifts every cell
// one place toward the head. The chain updates at the transfer edge and the
// result is shown on rsp_o with strobe high for the following cycle, during
// which busy is high and no new item is taken. The receiver cannot stall:
// a result is there for exactly one cycle and must be captured then. An
// insert into a full chain is dropped with accepted low; a schedule on an
// empty chain returns found low with zero id and run time.
module highest_priority_ready_queue_top #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire hpq_pkg::in_item_t  req_i,
  output logic                    busy,
  output logic                    strobe,
  output hpq_pkg::out_item_t      rsp_o
);

  `include "highest_priority_ready_queue_top_assert.svh"

  // chain taps: index i is cell i, index QUEUE_DEPTH is the empty tail
  logic [QUEUE_DEPTH:0]         tap_valid;
  logic [7:0]                   tap_id    [QUEUE_DEPTH+1];
  logic [PRIORITY_BITS-1:0]     tap_prio  [QUEUE_DEPTH+1];
  logic [15:0]                  tap_burst [QUEUE_DEPTH+1];
  // ge flag chain: index i feeds cell i, index 0 is a sentinel that is always set
  logic [QUEUE_DEPTH:0]         ge_chain;

  logic                         take;
  logic                         full;
  hpq_pkg::cell_cmd_t           cmd;
  logic [PRIORITY_BITS-1:0]     new_prio;
  logic [QUEUE_DEPTH-1:0]       occ;

  hpq_pkg::out_item_t           rsp_q, rsp_d;
  logic                         strobe_q;

  // one item in flight: the result cycle blocks the next transfer
  assign busy   = strobe_q;
  assign take   = start && !busy;
  assign full   = tap_valid[QUEUE_DEPTH-1];

  assign cmd.insert  = take && (req_i.func == hpq_pkg::FUNC_INSERT) && !full;
  assign cmd.extract = take && (req_i.func == hpq_pkg::FUNC_SCHEDULE);

  // only the low priority bits are kept
  assign new_prio = PRIORITY_BITS'(req_i.priority_req);

  // tail beyond the last cell is always empty
  assign tap_valid[QUEUE_DEPTH] = 1'b0;
  assign tap_id[QUEUE_DEPTH]    = '0;
  assign tap_prio[QUEUE_DEPTH]  = '0;
  assign tap_burst[QUEUE_DEPTH] = '0;
  assign ge_chain[0]            = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    // left neighbor data; cell 0 never takes from the left, it gets the new entry
    logic                     l_valid;
    logic [7:0]               l_id;
    logic [PRIORITY_BITS-1:0] l_prio;
    logic [15:0]              l_burst;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_id    = '0;
      assign l_prio  = '0;
      assign l_burst = '0;
    end else begin : g_body
      assign l_valid = tap_valid[i-1];
      assign l_id    = tap_id[i-1];
      assign l_prio  = tap_prio[i-1];
      assign l_burst = tap_burst[i-1];
    end

    hpq_cell #(
      .PrioBits (PRIORITY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .new_id_i      (req_i.proc_id),
      .new_prio_i    (new_prio),
      .new_burst_i   (req_i.burst_time),
      .left_ge_i     (ge_chain[i]),
      .left_valid_i  (l_valid),
      .left_id_i     (l_id),
      .left_prio_i   (l_prio),
      .left_burst_i  (l_burst),
      .right_valid_i (tap_valid[i+1]),
      .right_id_i    (tap_id[i+1]),
      .right_prio_i  (tap_prio[i+1]),
      .right_burst_i (tap_burst[i+1]),
      .ge_o          (ge_chain[i+1]),
      .valid_o       (tap_valid[i]),
      .id_o          (tap_id[i]),
      .prio_o        (tap_prio[i]),
      .burst_o       (tap_burst[i])
    );
  end

  assign occ = tap_valid[QUEUE_DEPTH-1:0];

  // result is built from the chain as it stands before the update
  always_comb begin
    rsp_d.accepted  = cmd.insert;
    rsp_d.found     = 1'b0;
    rsp_d.chosen_id = '0;
    rsp_d.run_time  = '0;
    if (cmd.extract && tap_valid[0]) begin
      rsp_d.found     = 1'b1;
      rsp_d.chosen_id = tap_id[0];
      rsp_d.run_time  = tap_burst[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rsp_q <= rsp_d;
    end
  end

  assign strobe = strobe_q;
  assign rsp_o  = rsp_q;

  // occupied cells always form an unbroken run from the head
  `HPQ_ASSERT_SAME(a_occ_contiguous, 1'b1, ((occ + 1'b1) & occ) == '0,
    "occupied cells are not contiguous from the head")

  // a stored insert adds exactly one entry
  `HPQ_ASSERT_NEXT(a_insert_count, cmd.insert,
    $countones(occ) == $past($countones(occ)) + 1, "insert did not add one entry")

  // a successful schedule removes exactly one entry
  `HPQ_ASSERT_NEXT(a_extract_count, cmd.extract && tap_valid[0],
    $countones(occ) == $past($countones(occ)) - 1, "schedule did not remove one entry")

  // a result never reports both an insert and a schedule outcome
  `HPQ_ASSERT_SAME(a_rsp_exclusive, strobe_q, !(rsp_q.accepted && rsp_q.found),
    "result flags both accepted and found")

endmodule

`default_nettype wire
